[src/text_console_writer_macros.svh]
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH
`ifndef ASSERT_OFF
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[src/tcw_pkg.sv]
// Package for the text console writer: constants, microcode types and program.
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  // cursor_pos is always reported with a stride of 80 columns
  localparam int POS_STRIDE        = 80;

  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR      = 8'h24;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] BG_MASK        = 8'hF0;
  localparam logic [7:0] BASE_COLOR_RST = 8'h07;

  // register word index (paddr bit 2)
  localparam logic REG_BASE_COLOR = 1'b0;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // microcode step addresses
  typedef enum logic [2:0] {
    U_ZERO,
    U_IDLE,
    U_PUT,
    U_SCR_RD,
    U_SCR_WR,
    U_FILL,
    U_RD,
    U_DONE
  } upc_e;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_COPY_RD,
    MEM_COPY_WR,
    MEM_FILL,
    MEM_ZERO,
    MEM_READ
  } mem_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_START,
    COND_SCROLL,
    COND_COPY_MORE,
    COND_FILL_MORE
  } cond_e;

  typedef struct packed {
    mem_op_e mem_op;
    logic    cur_put;
    logic    ptr_inc;
    cond_e   cond;
    logic    dispatch;
    upc_e    target;
    upc_e    fall;
    logic    emit;
  } uword_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // control store: one word per step
  function automatic uword_t ucode(upc_e step);
    uword_t w;
    w = '{mem_op: MEM_NONE, cur_put: 1'b0, ptr_inc: 1'b0, cond: COND_NEVER,
          dispatch: 1'b0, target: U_IDLE, fall: U_IDLE, emit: 1'b0};
    unique case (step)
      U_ZERO: begin
        w.mem_op  = MEM_ZERO;
        w.ptr_inc = 1'b1;
        w.cond    = COND_FILL_MORE;
        w.target  = U_ZERO;
      end
      U_IDLE: begin
        w.cond     = COND_START;
        w.dispatch = 1'b1;
      end
      U_PUT: begin
        w.mem_op  = MEM_PUT;
        w.cur_put = 1'b1;
        w.cond    = COND_SCROLL;
        w.target  = U_SCR_RD;
        w.emit    = 1'b1;
      end
      U_SCR_RD: begin
        w.mem_op = MEM_COPY_RD;
        w.fall   = U_SCR_WR;
      end
      U_SCR_WR: begin
        w.mem_op  = MEM_COPY_WR;
        w.ptr_inc = 1'b1;
        w.cond    = COND_COPY_MORE;
        w.target  = U_SCR_RD;
        w.fall    = U_FILL;
      end
      U_FILL: begin
        w.mem_op  = MEM_FILL;
        w.ptr_inc = 1'b1;
        w.cond    = COND_FILL_MORE;
        w.target  = U_FILL;
        w.emit    = 1'b1;
      end
      U_RD: begin
        w.mem_op = MEM_READ;
        w.fall   = U_DONE;
      end
      U_DONE: begin
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h = '{ok: 1'b0, val: 4'h0};
    if (c >= 8'h30 && c <= 8'h39) begin
      h = '{ok: 1'b1, val: 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h = '{ok: 1'b1, val: 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h = '{ok: 1'b1, val: 4'(c - 8'h37)};
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[src/text_console_writer.sv]
// Text console writer: microcoded character-cell console with APB register.
// Steps: a put writes its cell in U_PUT; reads and unused requests answer in U_DONE
// (a read after U_RD); a put that scrolls copies W*(H-1) cells (U_SCR_RD, U_SCR_WR),
// then blanks the last row (U_FILL); a clear blanks all W*H cells in U_FILL.
// Requests are taken only while busy is low; done_o cannot be stalled by the receiver.
// Reset: a clearing pass zeroes all W*H cells (busy high); APB is live.
`default_nettype none
`include "text_console_writer_macros.svh"

module text_console_writer #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  ch_i,
  input  logic        colored_i,
  input  logic        end_of_string_i,
  input  logic [10:0] cell_index_i,
  // result channel
  output logic        done_o,
  output logic [10:0] cursor_pos_o,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic        scrolled_o,
  output logic [15:0] read_data_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(SCREEN_WIDTH);
  localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
  // last destination cell of the scroll copy, last cell of the store
  localparam int COPY_LAST = SCREEN_WIDTH * (SCREEN_HEIGHT - 1) - 1;
  localparam int FILL_LAST = CELLS - 1;

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  tcw_pkg::upc_e   upc_q, upc_d;
  tcw_pkg::uword_t uw;
  logic            cond_true;
  logic            emit;
  logic            accept;
  tcw_pkg::upc_e   disp;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [7:0]        color_q, color_d;
  logic [7:0]        base_q, base_d;
  logic              esc_q, esc_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              scr_q, scr_d;

  // latched request
  tcw_pkg::req_e req_q;
  logic [7:0]    ch_q;
  logic          colored_q;
  logic          eos_q;
  logic [10:0]   idx_q;

  // cell memory
  logic [15:0]       cell_mem_q [CELLS];
  logic [15:0]       rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  // result registers
  logic        done_q;
  logic [10:0] pos_q;
  logic [4:0]  orow_q;
  logic [6:0]  ocol_q;
  logic        oscr_q;
  logic [15:0] ord_q;

  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // Put decode: escape handling, newline, wrap and scroll detection
  // ---------------------------------------------------------------------------
  tcw_pkg::hex_t     hex;
  logic              esc_start;
  logic              is_nl;
  logic              draw;
  logic              advance;
  logic              col_last;
  logic              row_last;
  logic              next_row_evt;
  logic              scroll_need;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] copy_src;
  logic              rd_ok;

  assign hex       = tcw_pkg::hex_decode(ch_q);
  // '$' opens an escape only in colored mode and not on the last character
  assign esc_start = !esc_q && colored_q && (ch_q == tcw_pkg::CH_DOLLAR) && !eos_q;
  assign is_nl     = (ch_q == tcw_pkg::CH_NEWLINE);
  // a pending escape swallows this character as the color digit
  assign advance   = !esc_q && !esc_start;
  assign draw      = advance && !is_nl;
  assign col_last  = (col_q == COL_W'(SCREEN_WIDTH - 1));
  assign row_last  = (row_q == ROW_W'(SCREEN_HEIGHT - 1));
  assign next_row_evt = advance && (is_nl || col_last);
  assign scroll_need  = next_row_evt && row_last;

  assign cur_addr = ADDR_W'(32'(row_q) * SCREEN_WIDTH + 32'(col_q));
  assign copy_src = ADDR_W'(32'(ptr_q) + SCREEN_WIDTH);
  assign rd_ok    = (32'(idx_q) < CELLS);

  // ---------------------------------------------------------------------------
  // Control store and jump logic
  // ---------------------------------------------------------------------------
  assign uw     = tcw_pkg::ucode(upc_q);
  assign busy   = (upc_q != tcw_pkg::U_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cond_true = 1'b0;
    unique case (uw.cond)
      tcw_pkg::COND_NEVER:     cond_true = 1'b0;
      tcw_pkg::COND_START:     cond_true = start;
      tcw_pkg::COND_SCROLL:    cond_true = scroll_need;
      tcw_pkg::COND_COPY_MORE: cond_true = (ptr_q != ADDR_W'(COPY_LAST));
      tcw_pkg::COND_FILL_MORE: cond_true = (ptr_q != ADDR_W'(FILL_LAST));
      default:                 cond_true = 1'b0;
    endcase
  end

  // request dispatch out of the idle step; clear reuses the fill loop
  always_comb begin
    disp = tcw_pkg::U_DONE;
    unique case (tcw_pkg::req_e'(req_type_i))
      tcw_pkg::REQ_PUT:   disp = tcw_pkg::U_PUT;
      tcw_pkg::REQ_CLEAR: disp = tcw_pkg::U_FILL;
      tcw_pkg::REQ_READ:  disp = tcw_pkg::U_RD;
      tcw_pkg::REQ_NONE:  disp = tcw_pkg::U_DONE;
    endcase
  end

  // next step
  always_comb begin
    if (cond_true) begin
      upc_d = uw.dispatch ? disp : uw.target;
    end else begin
      upc_d = uw.fall;
    end
  end

  // a result leaves when an emitting step falls through
  assign emit = uw.emit && !cond_true;

  // ---------------------------------------------------------------------------
  // Memory controls decoded from the control word
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = ptr_q;
    raddr  = copy_src;
    wdata  = '0;
    unique case (uw.mem_op)
      tcw_pkg::MEM_NONE: begin
        mem_we = 1'b0;
      end
      tcw_pkg::MEM_PUT: begin
        mem_we = draw;
        waddr  = cur_addr;
        wdata  = {color_q, ch_q};
      end
      tcw_pkg::MEM_COPY_RD: begin
        mem_re = 1'b1;
        raddr  = copy_src;
      end
      tcw_pkg::MEM_COPY_WR: begin
        mem_we = 1'b1;
        wdata  = rdata_q;
      end
      tcw_pkg::MEM_FILL: begin
        mem_we = 1'b1;
        wdata  = {color_q, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::MEM_ZERO: begin
        mem_we = 1'b1;
        wdata  = '0;
      end
      tcw_pkg::MEM_READ: begin
        mem_re = 1'b1;
        raddr  = ADDR_W'(idx_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= cell_mem_q[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::REG_BASE_COLOR);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    color_d = color_q;
    base_d  = base_q;
    esc_d   = esc_q;
    ptr_d   = ptr_q;
    scr_d   = scr_q;

    if (accept) begin
      ptr_d = '0;
      scr_d = 1'b0;
    end
    if (uw.ptr_inc) begin
      ptr_d = ptr_q + ADDR_W'(1);
    end

    if (uw.cur_put) begin
      // cursor: wrap to the next row; at the bottom the row stays and we scroll
      if (next_row_evt) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + ROW_W'(1);
        end
      end else if (draw) begin
        col_d = col_q + COL_W'(1);
      end
      // escape: digit replaces the foreground nibble of the base color, bad digit is dropped
      if (esc_q) begin
        esc_d = 1'b0;
        if (hex.ok) begin
          color_d = (base_q & tcw_pkg::BG_MASK) | {4'h0, hex.val};
        end
      end else if (esc_start) begin
        esc_d = 1'b1;
      end
      if (scroll_need) begin
        scr_d = 1'b1;
      end
    end

    // end of string restores the color after any scroll has been blanked
    if (emit && (req_q == tcw_pkg::REQ_PUT) && eos_q) begin
      color_d = base_q;
      esc_d   = 1'b0;
    end

    if (cfg_wr) begin
      base_d  = pwdata[7:0];
      color_d = pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q   <= tcw_pkg::U_ZERO;
      row_q   <= '0;
      col_q   <= '0;
      color_q <= tcw_pkg::BASE_COLOR_RST;
      base_q  <= tcw_pkg::BASE_COLOR_RST;
      esc_q   <= 1'b0;
      ptr_q   <= '0;
      scr_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      row_q   <= row_d;
      col_q   <= col_d;
      color_q <= color_d;
      base_q  <= base_d;
      esc_q   <= esc_d;
      ptr_q   <= ptr_d;
      scr_q   <= scr_d;
      done_q  <= emit;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= tcw_pkg::req_e'(req_type_i);
      ch_q      <= ch_i;
      colored_q <= colored_i;
      eos_q     <= end_of_string_i;
      idx_q     <= cell_index_i;
    end
    if (emit) begin
      pos_q  <= 11'(32'(row_d) * tcw_pkg::POS_STRIDE + 32'(col_d));
      orow_q <= 5'(row_d);
      ocol_q <= 7'(col_d);
      oscr_q <= scr_q;
      ord_q  <= ((req_q == tcw_pkg::REQ_READ) && rd_ok) ? rdata_q : 16'h0000;
    end
  end

  assign done_o       = done_q;
  assign cursor_pos_o = pos_q;
  assign cursor_row_o = orow_q;
  assign cursor_col_o = ocol_q;
  assign scrolled_o   = oscr_q;
  assign read_data_o  = ord_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tcw_pkg::REG_BASE_COLOR) ? 32'(base_q) : 32'h0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCW_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted request did not start")
  `TCW_ASSERT(a_idle_no_write, (upc_q == tcw_pkg::U_IDLE) |-> !mem_we, "memory write while idle")
  `TCW_ASSERT(a_done_after_work, done_o |-> $past(busy), "result without work")
  `TCW_ASSERT(a_scroll_cursor, (done_o && scrolled_o) |-> (col_q == '0 && row_last), "bad cursor after scroll")
  `TCW_ASSERT_ALWAYS(a_cursor_range, (32'(row_q) < SCREEN_HEIGHT) && (32'(col_q) < SCREEN_WIDTH), "cursor out of screen")

endmodule

`default_nettype wire
